// ===== rtl/stt_pkg.sv =====
// package: token kinds, scan states, result record and character helpers
`timescale 1ns / 1ps
package stt_pkg;

  localparam int OFF_W = 16;
  localparam int LEN_W = 17;
  localparam logic [30:0] INT_SAT = 31'h7FFFFFFF;
  localparam logic [3:0] FRAC_KEEP = 4'd9;

  typedef enum logic [3:0] {
    TK_SYMBOL    = 4'd0,
    TK_STRING    = 4'd1,
    TK_NUMBER    = 4'd2,
    TK_LITERAL   = 4'd3,
    TK_IDENT     = 4'd4,
    TK_NAMESPACE = 4'd5,
    TK_CMD       = 4'd6,
    TK_CMD_BLOCK = 4'd7,
    TK_ID        = 4'd8,
    TK_ID32      = 4'd9,
    TK_ID64      = 4'd10,
    TK_END       = 4'd11
  } token_kind_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SLASH, S_SLASH2, S_SLSTAR, S_LINE, S_BLOCK, S_MINUS,
    S_MINUSDOT, S_PLUS, S_PLUSDOT, S_DOT, S_COLON, S_STR, S_IDENT,
    S_I, S_ID, S_ID3, S_ID32, S_ID6, S_ID64, S_LIT, S_INT, S_FRAC
  } scan_state_t;

  typedef struct packed {
    logic [3:0]       token_kind;
    logic [7:0]       symbol_char;
    logic [OFF_W-1:0] start_offset;
    logic [LEN_W-1:0] token_length;
    logic             is_negative;
    logic [30:0]      integer_part;
    logic [29:0]      fraction_part;
    logic [3:0]       fraction_digits;
    logic             last_of_run;
  } token_t;

  // classified byte travelling from front to back: up to three tokens
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
    token_t     tok2;
  } run_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C ||
           b == 8'h0A || b == 8'h0D;
  endfunction

endpackage

// ===== rtl/stt_if.sv =====
// valid/ready channel interfaces for text bytes, tokens and configuration
`timescale 1ns / 1ps
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  symbol_char;
  logic [15:0] start_offset;
  logic [16:0] token_length;
  logic        is_negative;
  logic [30:0] integer_part;
  logic [29:0] fraction_part;
  logic [3:0]  fraction_digits;
  logic        last_of_run;
  modport source (output valid, output token_kind, output symbol_char,
    output start_offset, output token_length, output is_negative,
    output integer_part, output fraction_part, output fraction_digits,
    output last_of_run, input ready);
  modport sink (input valid, input token_kind, input symbol_char,
    input start_offset, input token_length, input is_negative,
    input integer_part, input fraction_part, input fraction_digits,
    input last_of_run, output ready);
endinterface

interface stt_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stt_front.sv =====
// front: scanner state machine, one byte per cycle while the queue is ready, builds the token run
`timescale 1ns / 1ps
module stt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           verbatim_mode,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           in_ready,
  input  logic           q_ready,
  output logic           q_push,
  output stt_pkg::run_t  q_data
);
  import stt_pkg::*;

  scan_state_t     state, state_next;
  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [OFF_W-1:0] token_start, token_start_next;
  logic             escape_pending, escape_next;
  logic             number_sign, sign_next;
  logic [30:0]      int_acc, int_next;
  logic [29:0]      frac_acc, frac_next;
  logic [3:0]       frac_cnt, cnt_next;
  logic             ended;
  run_t             run;

  logic [34:0] int_mul;
  logic [34:0] int_sum;
  logic [29:0] frac_step;

  assign in_ready = q_ready;
  assign q_push   = in_valid && in_ready;
  assign q_data   = run;

  // one multiply-add per digit with saturation
  assign int_mul   = {1'b0, int_acc, 3'b000} + {3'b000, int_acc, 1'b0};
  assign int_sum   = int_mul + {31'd0, in_byte[3:0]};
  assign frac_step = {frac_acc[26:0], 3'b000} + {frac_acc[28:0], 1'b0}
                     + {26'd0, in_byte[3:0]};

  // next state and emitted tokens
  always_comb begin
    token_t t;
    logic   go;
    logic   done;
    logic   frac_d;
    scan_state_t st;
    int_next        = int_acc;
    frac_next       = frac_acc;
    cnt_next        = frac_cnt;
    sign_next       = number_sign;
    escape_next     = escape_pending;
    token_start_next = token_start;
    state_next      = state;
    ended           = 1'b0;
    run             = '0;
    st              = state;
    go              = 1'b1;
    frac_d          = 1'b0;
    for (int pass = 0; pass < 3; pass++) begin
      done = 1'b0;
      t = '0;
      t.start_offset = token_start_next;
      if (go) begin
        go = 1'b0;
        unique case (st)
          S_IDLE: begin
            token_start_next = byte_offset;
            sign_next = 1'b0;
            int_next = '0;
            frac_next = '0;
            cnt_next = '0;
            escape_next = 1'b0;
            t.start_offset = byte_offset;
            if (in_byte == 8'h00) begin
              t.token_kind = TK_END; t.token_length = 17'd1; done = 1'b1;
              ended = 1'b1;
            end else if (is_space(in_byte)) begin
            end else if (in_byte == 8'h2F) st = S_SLASH;
            else if (in_byte == 8'h2D) st = S_MINUS;
            else if (in_byte == 8'h22) begin
              token_start_next = byte_offset + OFF_W'(1); st = S_STR;
            end else if (in_byte == 8'h49) st = S_I;
            else if (in_byte == 8'h3A) st = S_COLON;
            else if (is_letter(in_byte) || in_byte == 8'h5F) st = S_IDENT;
            else if (is_digit(in_byte)) begin
              if (verbatim_mode) st = S_LIT;
              else begin int_next = {27'd0, in_byte[3:0]}; st = S_INT; end
            end else if (!verbatim_mode && in_byte == 8'h2B) st = S_PLUS;
            else if (!verbatim_mode && in_byte == 8'h2E) st = S_DOT;
            else begin
              t.symbol_char = in_byte; t.token_length = 17'd1; done = 1'b1;
            end
          end
          S_SLASH: begin
            if (in_byte == 8'h2F) st = S_SLASH2;
            else if (in_byte == 8'h2A) st = S_SLSTAR;
            else begin
              t.symbol_char = 8'h2F; t.token_length = 17'd1; done = 1'b1;
              st = S_IDLE; go = 1'b1;
            end
          end
          S_SLASH2: begin
            if (in_byte == 8'h21) begin
              t.token_kind = TK_CMD; t.token_length = 17'd3; done = 1'b1;
              st = S_IDLE;
            end else begin st = S_LINE; go = 1'b1; end
          end
          S_SLSTAR: begin
            if (in_byte == 8'h21) begin
              t.token_kind = TK_CMD_BLOCK; t.token_length = 17'd3; done = 1'b1;
              st = S_IDLE;
            end else begin escape_next = 1'b0; st = S_BLOCK; go = 1'b1; end
          end
          S_LINE: begin
            if (in_byte == 8'h00) begin st = S_IDLE; go = 1'b1; end
            else if (in_byte == 8'h0A || in_byte == 8'h0D) st = S_IDLE;
          end
          S_BLOCK: begin
            if (in_byte == 8'h00) begin st = S_IDLE; go = 1'b1; end
            else if (escape_next && in_byte == 8'h2F) begin
              escape_next = 1'b0; st = S_IDLE;
            end else escape_next = (in_byte == 8'h2A);
          end
          S_MINUS: begin
            if (in_byte == 8'h2D) st = S_LINE;
            else if (!verbatim_mode && is_digit(in_byte)) begin
              sign_next = 1'b1; int_next = {27'd0, in_byte[3:0]}; st = S_INT;
            end else if (!verbatim_mode && in_byte == 8'h2E) begin
              sign_next = 1'b1; st = S_MINUSDOT;
            end else begin
              t.symbol_char = 8'h2D; t.token_length = 17'd1; done = 1'b1;
              st = S_IDLE; go = 1'b1;
            end
          end
          S_PLUS: begin
            if (is_digit(in_byte)) begin
              int_next = {27'd0, in_byte[3:0]}; st = S_INT;
            end else if (in_byte == 8'h2E) st = S_PLUSDOT;
            else begin
              t.symbol_char = 8'h2B; t.token_length = 17'd1; done = 1'b1;
              st = S_IDLE; go = 1'b1;
            end
          end
          S_MINUSDOT, S_PLUSDOT: begin
            if (is_digit(in_byte)) begin frac_d = 1'b1; st = S_FRAC; end
            else begin
              sign_next = 1'b0;
              t.symbol_char = (st == S_MINUSDOT) ? 8'h2D : 8'h2B;
              t.token_length = 17'd1; done = 1'b1;
              token_start_next = byte_offset - OFF_W'(1);
              st = S_DOT; go = 1'b1;
            end
          end
          S_DOT: begin
            if (is_digit(in_byte)) begin frac_d = 1'b1; st = S_FRAC; end
            else begin
              t.symbol_char = 8'h2E; t.token_length = 17'd1; done = 1'b1;
              st = S_IDLE; go = 1'b1;
            end
          end
          S_COLON: begin
            if (in_byte == 8'h3A) begin
              t.token_kind = TK_NAMESPACE; t.token_length = 17'd2; done = 1'b1;
              st = S_IDLE;
            end else begin
              t.symbol_char = 8'h3A; t.token_length = 17'd1; done = 1'b1;
              st = S_IDLE; go = 1'b1;
            end
          end
          S_STR: begin
            t.token_kind = TK_STRING;
            t.token_length = {1'b0, byte_offset - token_start_next};
            if (in_byte == 8'h00) begin done = 1'b1; st = S_IDLE; go = 1'b1; end
            else if (escape_next) escape_next = 1'b0;
            else if (in_byte == 8'h5C) escape_next = 1'b1;
            else if (in_byte == 8'h22) begin done = 1'b1; st = S_IDLE; end
          end
          S_I: begin
            if (in_byte == 8'h44) st = S_ID;
            else begin st = S_IDENT; go = 1'b1; end
          end
          S_ID: begin
            if (in_byte == 8'h28) begin
              t.token_kind = TK_ID; t.token_length = 17'd3; done = 1'b1;
              st = S_IDLE;
            end else if (in_byte == 8'h33) st = S_ID3;
            else if (in_byte == 8'h36) st = S_ID6;
            else begin st = S_IDENT; go = 1'b1; end
          end
          S_ID3: begin
            if (in_byte == 8'h32) st = S_ID32;
            else begin st = S_IDENT; go = 1'b1; end
          end
          S_ID6: begin
            if (in_byte == 8'h34) st = S_ID64;
            else begin st = S_IDENT; go = 1'b1; end
          end
          S_ID32, S_ID64: begin
            if (in_byte == 8'h28) begin
              t.token_kind = (st == S_ID32) ? TK_ID32 : TK_ID64;
              t.token_length = 17'd5; done = 1'b1; st = S_IDLE;
            end else begin st = S_IDENT; go = 1'b1; end
          end
          S_IDENT: begin
            if (!(is_letter(in_byte) || is_digit(in_byte) || in_byte == 8'h5F)) begin
              t.token_kind = TK_IDENT;
              t.token_length = {1'b0, byte_offset - token_start_next};
              done = 1'b1; st = S_IDLE; go = 1'b1;
            end
          end
          S_LIT: begin
            if (!is_digit(in_byte)) begin
              t.token_kind = TK_LITERAL;
              t.token_length = {1'b0, byte_offset - token_start_next};
              done = 1'b1; st = S_IDLE; go = 1'b1;
            end
          end
          S_INT, S_FRAC: begin
            if (is_digit(in_byte)) begin
              if (st == S_INT) int_next = (int_sum > {4'd0, INT_SAT}) ? INT_SAT
                                                                      : int_sum[30:0];
              else frac_d = 1'b1;
            end else if (st == S_INT && in_byte == 8'h2E) st = S_FRAC;
            else begin
              t.token_kind = TK_NUMBER;
              t.token_length = {1'b0, byte_offset - token_start_next};
              t.is_negative = sign_next;
              t.integer_part = int_next;
              t.fraction_part = frac_next;
              t.fraction_digits = cnt_next;
              done = 1'b1; st = S_IDLE; go = 1'b1;
            end
          end
          default: st = S_IDLE;
        endcase
        if (done) begin
          case (run.count)
            2'd0: run.tok0 = t;
            2'd1: run.tok1 = t;
            default: run.tok2 = t;
          endcase
          if (run.count != 2'd3) run.count = run.count + 2'd1;
        end
      end
    end
    // fraction digit, kept while under the cap
    if (frac_d && frac_cnt < FRAC_KEEP) begin
      frac_next = frac_step;
      cnt_next  = frac_cnt + 4'd1;
    end
    state_next = st;
    case (run.count)
      2'd1: run.tok0.last_of_run = 1'b1;
      2'd2: run.tok1.last_of_run = 1'b1;
      2'd3: run.tok2.last_of_run = 1'b1;
      default: ;
    endcase
    byte_offset_next = ended ? '0 : byte_offset + OFF_W'(1);
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_offset <= '0;
      token_start <= '0;
      escape_pending <= 1'b0;
      number_sign <= 1'b0;
      int_acc <= '0;
      frac_acc <= '0;
      frac_cnt <= '0;
    end else if (q_push) begin
      state <= state_next;
      byte_offset <= byte_offset_next;
      token_start <= token_start_next;
      escape_pending <= escape_next;
      number_sign <= sign_next;
      int_acc <= int_next;
      frac_acc <= frac_next;
      frac_cnt <= cnt_next;
    end
  end

  ap_frac_cap: assert property (@(posedge clk) disable iff (rst)
    frac_cnt <= FRAC_KEEP) else $error("fraction count past cap");
  ap_int_sat: assert property (@(posedge clk) disable iff (rst)
    int_acc <= INT_SAT) else $error("integer accumulator overflow");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(q_push) |-> $stable(byte_offset)) else $error("offset moved without beat");
endmodule

// ===== rtl/stt_back.sv =====
// back: two-entry run queue and token serializer with output register
`timescale 1ns / 1ps
module stt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_push,
  input  stt_pkg::run_t   q_data,
  output logic            q_ready,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_ready,
  output stt_pkg::token_t out_tok
);
  import stt_pkg::*;

  run_t       fifo [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic [1:0] sub;
  logic       head_valid;
  logic       pop;
  logic       take;
  token_t     head_tok;
  run_t       head;

  assign head       = fifo[rd_ptr];
  assign head_valid = fill != 2'd0;
  assign q_ready    = fill != 2'd2;
  assign busy       = head_valid || out_valid;

  // pick the current token of the head run
  always_comb begin
    case (sub)
      2'd0:    head_tok = head.tok0;
      2'd1:    head_tok = head.tok1;
      default: head_tok = head.tok2;
    endcase
  end

  // a run with no tokens drops straight out; otherwise load the output register
  assign take = head_valid && head.count != 2'd0 && (!out_valid || out_ready);
  assign pop  = head_valid && (head.count == 2'd0 ||
                (take && ({1'b0, sub} + 3'd1 == {1'b0, head.count})));

  always_ff @(posedge clk) begin
    if (q_push) fifo[wr_ptr] <= q_data;
    if (take) out_tok <= head_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
      sub <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, q_push} - {1'b0, pop};
      if (pop) sub <= '0;
      else if (take) sub <= sub + 2'd1;
      if (take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  ap_fill: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2) else $error("queue overfilled");
  ap_sub: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.count != 2'd0 |-> {1'b0, sub} < {1'b0, head.count})
    else $error("token index past run");
  ap_last: assert property (@(posedge clk) disable iff (rst)
    pop && take |=> out_tok.last_of_run) else $error("run closed without last mark");
endmodule

// ===== rtl/source_text_tokenizer_core.sv =====
// top level: streaming source text tokenizer
//   channel  dir  beat
//   text     in   text_byte
//   tokens   out  one token record, last_of_run on the final one of a byte
//   cfg      in   verbatim_mode
// One byte accepted per cycle while the two-run queue has room; each byte
// yields zero to three tokens, sent one per cycle while tokens.ready holds,
// from a registered output fed by the run queue. Reset (rst, synchronous)
// clears the scanner to idle, offset zero, and empties the queue.
// cfg is taken only when the queue and output register are empty.
`timescale 1ns / 1ps
module source_text_tokenizer_core (
  input logic clk,
  input logic rst,
  stt_byte_if.sink    text,
  stt_token_if.source tokens,
  stt_cfg_if.sink     cfg
);
  import stt_pkg::*;

  logic   verbatim_mode;
  logic   q_ready, q_push, busy;
  run_t   q_data;
  token_t out_tok;

  // configuration register
  assign cfg.ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) verbatim_mode <= 1'b0;
    else if (cfg.valid && cfg.ready) verbatim_mode <= cfg.data;
  end

  stt_front u_front (
    .clk, .rst, .verbatim_mode,
    .in_valid(text.valid), .in_byte(text.text_byte), .in_ready(text.ready),
    .q_ready, .q_push, .q_data
  );

  stt_back u_back (
    .clk, .rst, .q_push, .q_data, .q_ready, .busy,
    .out_valid(tokens.valid), .out_ready(tokens.ready), .out_tok
  );

  assign tokens.token_kind      = out_tok.token_kind;
  assign tokens.symbol_char     = out_tok.symbol_char;
  assign tokens.start_offset    = out_tok.start_offset;
  assign tokens.token_length    = out_tok.token_length;
  assign tokens.is_negative     = out_tok.is_negative;
  assign tokens.integer_part    = out_tok.integer_part;
  assign tokens.fraction_part   = out_tok.fraction_part;
  assign tokens.fraction_digits = out_tok.fraction_digits;
  assign tokens.last_of_run     = out_tok.last_of_run;
endmodule
